/* design/scs_pkg.sv */
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the source comment scanner: byte codes,
// register indexes, scan modes and the item structs of both channels.
// ----------------------------------------------------------------------------
package scs_pkg;

    // Default offset counter width
    localparam int OFFSET_BITS_DEF = 32;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_START_OFFSET = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_FIRST_LINE   = 1'b1;

    // Line counter
    localparam int LINE_BITS = 32;
    localparam logic [LINE_BITS-1:0] LINE_MAX   = '1;
    localparam logic [LINE_BITS-1:0] LINE_RESET = LINE_BITS'(1);

    // Byte codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Comment kinds
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_BLOCK = 1'b1;

    // Scan modes, one-hot
    typedef enum logic [6:0] {
        MODE_NORMAL = 7'b0000001,
        MODE_SLASH  = 7'b0000010,
        MODE_STR    = 7'b0000100,
        MODE_ESC    = 7'b0001000,
        MODE_LINE   = 7'b0010000,
        MODE_BLOCK  = 7'b0100000,
        MODE_BSTAR  = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_in_window;
    } in_item_t;

    typedef struct packed {
        logic        comment_kind;
        logic [31:0] begin_offset;
        logic [31:0] end_offset;
        logic [31:0] start_line_no;
        logic [31:0] end_line_no;
    } out_item_t;

    typedef struct packed {
        logic                     wr_en;
        logic [CFG_IDX_BITS-1:0]  addr;
        logic [CFG_DATA_BITS-1:0] wdata;
    } cfg_wr_t;

endpackage

/* design/scs_core.sv */
// ----------------------------------------------------------------------------
// scs_core
// Scanner state and one-byte step: mode, offset and line counters, opener
// position, and the comment record a byte closes.
// ----------------------------------------------------------------------------
module scs_core #(
    parameter int OFFSET_BITS = scs_pkg::OFFSET_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  scs_pkg::cfg_wr_t  cfg,
    input  logic              step,
    input  scs_pkg::in_item_t item,
    output logic              res_valid,
    output scs_pkg::out_item_t res_item
);
    import scs_pkg::*;

    mode_t                   mode_reg,         mode_next;
    logic [OFFSET_BITS-1:0]  byte_offset_reg,  byte_offset_next;
    logic [LINE_BITS-1:0]    current_line_reg, current_line_next;
    logic [OFFSET_BITS-1:0]  open_offset_reg,  open_offset_next;
    logic [LINE_BITS-1:0]    open_line_reg,    open_line_next;

    logic [OFFSET_BITS-1:0]  off_plus1;
    mode_t                   mode_step;
    logic                    emit;
    logic                    emit_kind;
    logic [OFFSET_BITS-1:0]  emit_end;
    logic [LINE_BITS-1:0]    emit_eline;

    assign off_plus1 = byte_offset_reg + OFFSET_BITS'(1);

    always_comb
    begin
        mode_step        = mode_reg;
        open_offset_next = open_offset_reg;
        open_line_next   = open_line_reg;
        emit             = 1'b0;
        emit_kind        = KIND_LINE;
        emit_end         = off_plus1;
        emit_eline       = current_line_reg;

        case (mode_reg)
            MODE_SLASH:
            begin
                if (item.char_byte == CH_SLASH)
                    mode_step = MODE_LINE;
                else if (item.char_byte == CH_STAR)
                    mode_step = MODE_BLOCK;
                else if (item.char_byte == CH_QUOTE)
                    mode_step = MODE_STR;
                else
                    mode_step = MODE_NORMAL;
            end
            MODE_STR:
            begin
                if (item.char_byte == CH_BSLASH)
                    mode_step = MODE_ESC;
                else if (item.char_byte == CH_QUOTE)
                    mode_step = MODE_NORMAL;
            end
            MODE_ESC:
            begin
                mode_step = MODE_STR;
            end
            MODE_LINE:
            begin
                // newline stays outside the comment
                if (item.char_byte == CH_NL)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_LINE;
                    emit_end   = byte_offset_reg;
                    emit_eline = open_line_reg;
                    mode_step  = MODE_NORMAL;
                end
            end
            MODE_BLOCK:
            begin
                if (item.char_byte == CH_STAR)
                    mode_step = MODE_BSTAR;
            end
            MODE_BSTAR:
            begin
                if (item.char_byte == CH_SLASH)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_BLOCK;
                    emit_end   = off_plus1;
                    emit_eline = current_line_reg;
                    mode_step  = MODE_NORMAL;
                end
                else if (item.char_byte != CH_STAR)
                begin
                    mode_step = MODE_BLOCK;
                end
            end
            default:
            begin
                if (item.char_byte == CH_QUOTE)
                begin
                    mode_step = MODE_STR;
                end
                else if (item.char_byte == CH_SLASH)
                begin
                    mode_step        = MODE_SLASH;
                    open_offset_next = byte_offset_reg;
                    open_line_next   = current_line_reg;
                end
                else
                begin
                    mode_step = MODE_NORMAL;
                end
            end
        endcase

        mode_next = mode_step;
        // window end closes an open comment and drops partial marks
        if (item.last_in_window)
        begin
            if (!emit && mode_step == MODE_LINE)
            begin
                emit       = 1'b1;
                emit_kind  = KIND_LINE;
                emit_end   = off_plus1;
                emit_eline = open_line_reg;
            end
            else if (!emit && (mode_step inside {MODE_BLOCK, MODE_BSTAR}))
            begin
                emit       = 1'b1;
                emit_kind  = KIND_BLOCK;
                emit_end   = off_plus1;
                emit_eline = current_line_reg;
            end
            mode_next = MODE_NORMAL;
        end

        // saturating line count
        if (item.char_byte == CH_NL && current_line_reg != LINE_MAX)
            current_line_next = current_line_reg + LINE_BITS'(1);
        else
            current_line_next = current_line_reg;
        byte_offset_next = off_plus1;
    end

    assign res_valid              = emit;
    assign res_item.comment_kind  = emit_kind;
    assign res_item.begin_offset  = 32'(open_offset_reg);
    assign res_item.end_offset    = 32'(emit_end);
    assign res_item.start_line_no = open_line_reg;
    assign res_item.end_line_no   = emit_eline;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NORMAL;
            byte_offset_reg  <= '0;
            current_line_reg <= LINE_RESET;
            open_offset_reg  <= '0;
            open_line_reg    <= LINE_RESET;
        end
        else
        begin
            if (step)
            begin
                mode_reg         <= mode_next;
                byte_offset_reg  <= byte_offset_next;
                current_line_reg <= current_line_next;
                open_offset_reg  <= open_offset_next;
                open_line_reg    <= open_line_next;
            end
            // register write loads its counter at once
            if (cfg.wr_en && cfg.addr == CFG_IDX_START_OFFSET)
                byte_offset_reg <= OFFSET_BITS'(cfg.wdata);
            if (cfg.wr_en && cfg.addr == CFG_IDX_FIRST_LINE)
                current_line_reg <= LINE_BITS'(cfg.wdata);
        end
    end

endmodule

/* design/source_comment_scanner_top.sv */
// ----------------------------------------------------------------------------
// source_comment_scanner_top
// C-style comment scanner: one source byte per item, one comment record out
// for each line or block comment found in the window.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock cycle and keeps that rate for as long
// as results are taken. An accepted byte lands in an input register; when the
// output register is free or being emptied, it steps the scanner state (one
// small mode/counter update) and any comment it closes is written to the
// output register, whose valid flag drives out_valid directly. A byte
// is taken while an earlier result waits; input stops only when the input
// register is full and the output register holds a result not yet taken.
// Double-quoted strings with backslash escapes are skipped; single quotes are
// ordinary bytes. A line comment ends before its newline or at the window
// end; a block comment ends after its closer or, if never closed, one past
// the window's last byte. The window end returns the scanner to normal mode,
// while the offset and line counters keep counting. Register 0 (start_offset)
// loads the offset counter and register 1 (first_line) the line counter at
// the write; write them only while the block is idle. Offsets wrap modulo
// 2^OFFSET_BITS and are reported in 32 bits; the line count saturates.
// ----------------------------------------------------------------------------
module source_comment_scanner_top #(
    parameter int OFFSET_BITS = scs_pkg::OFFSET_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [scs_pkg::CFG_IDX_BITS-1:0]      cfg_addr,
    input  logic [scs_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    // byte input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  scs_pkg::in_item_t                     in_item,
    // comment records
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output scs_pkg::out_item_t                    out_item
);
    import scs_pkg::*;

    // input register
    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    // output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;

    logic      advance;
    logic      core_valid;
    out_item_t core_item;
    cfg_wr_t   cfg;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.addr  = cfg_addr;
    assign cfg.wdata = cfg_wdata;

    // byte moves on when the output register is free or being emptied
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    scs_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .item      (s1_item_reg),
        .res_valid (core_valid),
        .res_item  (core_item)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && in_ready)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = core_valid;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_item;
        if (advance && core_valid)
            out_item_reg <= core_item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* design/scs_checker.sv */
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks for the source comment scanner, bound to the top level.
// ----------------------------------------------------------------------------
module scs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input scs_pkg::out_item_t                out_item
);
    import scs_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // input only backs up behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with output free");

    // a fresh result follows a byte accepted earlier through the input register
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching byte");

    // a line comment never spans lines
    a_line_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.comment_kind == KIND_LINE
            |-> out_item.end_line_no == out_item.start_line_no)
        else $error("line comment spans lines");

endmodule

bind source_comment_scanner_top scs_checker u_scs_checker (.*);
